/* sv/max_flow_augmenting_path_unit_assert.svh */
// Assertion macros shared by the max-flow checker.
`ifndef MAX_FLOW_AUGMENTING_PATH_UNIT_ASSERT_SVH
`define MAX_FLOW_AUGMENTING_PATH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MFAP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define MFAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define MFAP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mfap_pkg.sv */
// Shared types and constants of the max-flow unit.
`default_nettype none
package mfap_pkg;
   localparam int MAX_NODES  = 32;
   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int CNT_BITS   = NODE_BITS + 1;
   localparam int ADDR_BITS  = 2 * NODE_BITS;
   localparam int CAP_BITS   = 32;
   localparam int CAPIN_BITS = 32;
   localparam int FLOW_BITS  = 38;
   localparam int RES_BITS   = FLOW_BITS + 1;
   localparam int TOTAL_BITS = 37;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_NODE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SINK_NODE   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SAME_NODE = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_BFS_INIT, OP_Q_READ, OP_Q_TAKE, OP_SCAN,
      OP_W_PAR, OP_W_PARW, OP_W_RES, OP_U_PAR, OP_U_PARW, OP_U_FWD, OP_U_REV,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;      // edge beat accepted
      logic   load_rsp;  // move result into output register
   } cmd_type;

   typedef struct packed {
      logic run_ok;
      logic q_empty;
      logic sink_found;
      logic scan_done;
      logic at_src;
      logic clr_done;
   } sts_type;
endpackage
`default_nettype wire

/* sv/mfap_if.sv */
// Valid/ready channel interfaces for edge beats and result beats.
`default_nettype none
interface mfap_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  from_node;
   logic [4:0]  to_node;
   logic [31:0] edge_capacity;
   logic        last;
   modport source (output valid, from_node, to_node, edge_capacity, last, input ready);
   modport sink   (input valid, from_node, to_node, edge_capacity, last, output ready);
endinterface

interface mfap_rsp_if;
   logic        valid;
   logic        ready;
   logic [36:0] flow_sum;
   logic [1:0]  status;
   modport source (output valid, flow_sum, status, input ready);
   modport sink   (input valid, flow_sum, status, output ready);
endinterface
`default_nettype wire

/* sv/mfap_datapath.sv */
// Datapath: capacity/flow memories, BFS queue and parents, path walk, result.
`default_nettype none
module mfap_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mfap_pkg::cmd_type                    cmd,
   output mfap_pkg::sts_type                    sts,
   input  logic                                 csr_we,
   input  logic [mfap_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mfap_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [mfap_pkg::NODE_BITS-1:0]       from_node,
   input  logic [mfap_pkg::NODE_BITS-1:0]       to_node,
   input  logic [mfap_pkg::CAPIN_BITS-1:0]      edge_capacity,
   input  logic                                 last,
   output logic [mfap_pkg::TOTAL_BITS-1:0]      flow_sum,
   output logic [1:0]                           status
);
   import mfap_pkg::*;

   logic [CNT_BITS-1:0]  node_count_ff, node_count_in;
   logic [NODE_BITS-1:0] src_ff, src_in, snk_ff, snk_in;
   logic [CNT_BITS-1:0]  n_eff;

   logic [1:0]            stat_ff, stat_in;
   logic                  err_ff, err_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [FLOW_BITS-1:0]  aug_ff, aug_in;
   logic [MAX_NODES-1:0]  visited_ff, visited_in;
   logic [CNT_BITS-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [NODE_BITS-1:0]  u_ff, u_in;
   logic [CNT_BITS-1:0]   v_ff, v_in;
   logic                  pv_ff, pv_in;
   logic [NODE_BITS-1:0]  pidx_ff, pidx_in;
   logic [NODE_BITS-1:0]  vw_ff, vw_in, uw_ff, uw_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;
   logic [TOTAL_BITS-1:0] flow_sum_ff, flow_sum_in;
   logic [1:0]            status_ff, status_in;

   // memories
   logic [CAP_BITS-1:0]  cap_mem  [2**ADDR_BITS];
   logic [FLOW_BITS-1:0] flow_mem [2**ADDR_BITS];
   logic [NODE_BITS-1:0] par_mem  [MAX_NODES];
   logic [NODE_BITS-1:0] que_mem  [MAX_NODES];
   logic [CAP_BITS-1:0]  cap_rd_ff;
   logic [FLOW_BITS-1:0] flow_rd_ff;
   logic [NODE_BITS-1:0] par_rd_ff, que_rd_ff;

   logic                 cap_we, flow_we, par_we, que_we;
   logic [ADDR_BITS-1:0] cap_waddr, cap_raddr, flow_waddr, flow_raddr;
   logic [CAP_BITS-1:0]  cap_wdata;
   logic [FLOW_BITS-1:0] flow_wdata;
   logic [NODE_BITS-1:0] par_waddr, par_wdata, que_waddr, que_wdata;

   logic edge_ok, same_node, end_bad, scan_issue, hit, res_pos, at_src;
   logic signed [RES_BITS-1:0] res;

   always_comb begin
      if (node_count_ff < CNT_BITS'(2)) begin
         n_eff = CNT_BITS'(2);
      end else if (node_count_ff > CNT_BITS'(MAX_NODES)) begin
         n_eff = CNT_BITS'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign edge_ok   = ({1'b0, from_node} < n_eff) && ({1'b0, to_node} < n_eff);
   assign same_node = (src_ff == snk_ff);
   assign end_bad   = ({1'b0, src_ff} >= n_eff) || ({1'b0, snk_ff} >= n_eff);

   assign res = $signed({{(RES_BITS-CAP_BITS){1'b0}}, cap_rd_ff})
              - $signed({flow_rd_ff[FLOW_BITS-1], flow_rd_ff});
   assign res_pos    = !res[RES_BITS-1] && (res != '0);
   assign scan_issue = (cmd.op == OP_SCAN) && (v_ff < n_eff);
   assign hit        = (cmd.op == OP_SCAN) && pv_ff && !visited_ff[pidx_ff] && res_pos;
   assign at_src     = (uw_ff == src_ff);

   assign sts.run_ok     = !same_node && !end_bad;
   assign sts.q_empty    = (head_ff == tail_ff);
   assign sts.sink_found = visited_ff[snk_ff];
   assign sts.scan_done  = (v_ff >= n_eff) && !pv_ff;
   assign sts.at_src     = at_src;
   assign sts.clr_done   = (clr_ff == '1);

   // memory port selection
   always_comb begin
      cap_we    = 1'b0;
      cap_waddr = {from_node, to_node};
      cap_wdata = edge_capacity[CAP_BITS-1:0];
      if (cmd.op == OP_CLEAR) begin
         cap_we    = 1'b1;
         cap_waddr = clr_ff;
         cap_wdata = '0;
      end else if (cmd.load && edge_ok) begin
         cap_we = 1'b1;
      end
      cap_raddr = (cmd.op == OP_W_PARW) ? {par_rd_ff, vw_ff} : {u_ff, v_ff[NODE_BITS-1:0]};

      flow_we    = 1'b0;
      flow_waddr = clr_ff;
      flow_wdata = '0;
      unique case (cmd.op)
         OP_CLEAR: flow_we = 1'b1;
         OP_U_FWD: begin
            flow_we    = 1'b1;
            flow_waddr = {uw_ff, vw_ff};
            flow_wdata = flow_rd_ff + aug_ff;
         end
         OP_U_REV: begin
            flow_we    = 1'b1;
            flow_waddr = {vw_ff, uw_ff};
            flow_wdata = flow_rd_ff - aug_ff;
         end
         default: flow_we = 1'b0;
      endcase
      if (cmd.op == OP_U_FWD) begin
         flow_raddr = {vw_ff, uw_ff};
      end else if (cmd.op == OP_W_PARW || cmd.op == OP_U_PARW) begin
         flow_raddr = {par_rd_ff, vw_ff};
      end else begin
         flow_raddr = {u_ff, v_ff[NODE_BITS-1:0]};
      end

      par_we    = hit;
      par_waddr = pidx_ff;
      par_wdata = u_ff;

      que_we    = 1'b0;
      que_waddr = tail_ff[NODE_BITS-1:0];
      que_wdata = pidx_ff;
      if (cmd.op == OP_BFS_INIT) begin
         que_we    = 1'b1;
         que_waddr = '0;
         que_wdata = src_ff;
      end else if (hit && (tail_ff < CNT_BITS'(MAX_NODES))) begin
         que_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
      cap_rd_ff <= cap_mem[cap_raddr];
      if (flow_we) flow_mem[flow_waddr] <= flow_wdata;
      flow_rd_ff <= flow_mem[flow_raddr];
      if (par_we) par_mem[par_waddr] <= par_wdata;
      par_rd_ff <= par_mem[vw_ff];
      if (que_we) que_mem[que_waddr] <= que_wdata;
      que_rd_ff <= que_mem[head_ff[NODE_BITS-1:0]];
   end

   always_comb begin
      node_count_in = node_count_ff;
      src_in        = src_ff;
      snk_in        = snk_ff;
      stat_in       = stat_ff;
      err_in        = err_ff;
      total_in      = total_ff;
      aug_in        = aug_ff;
      visited_in    = visited_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      pv_in         = scan_issue;
      pidx_in       = v_ff[NODE_BITS-1:0];
      vw_in         = vw_ff;
      uw_in         = uw_ff;
      clr_in        = clr_ff;
      flow_sum_in   = flow_sum_ff;
      status_in     = status_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT:  node_count_in = csr_wdata[CNT_BITS-1:0];
            CSR_SOURCE_NODE: src_in = csr_wdata[NODE_BITS-1:0];
            CSR_SINK_NODE:   snk_in = csr_wdata[NODE_BITS-1:0];
            default:         ;
         endcase
      end

      if (cmd.load) begin
         if (!edge_ok) err_in = 1'b1;
         if (last) begin
            total_in = '0;
            if (same_node)    stat_in = ST_SAME_NODE;
            else if (end_bad) stat_in = ST_RANGE;
            else              stat_in = ST_OK;
         end
      end

      if (scan_issue) v_in = v_ff + CNT_BITS'(1);
      if (hit) begin
         visited_in[pidx_ff] = 1'b1;
         if (tail_ff < CNT_BITS'(MAX_NODES)) tail_in = tail_ff + CNT_BITS'(1);
      end

      unique case (cmd.op) inside
         OP_CLEAR: clr_in = clr_ff + ADDR_BITS'(1);
         OP_BFS_INIT: begin
            visited_in         = '0;
            visited_in[src_ff] = 1'b1;
            head_in            = '0;
            tail_in            = CNT_BITS'(1);
            aug_in             = '1;
            vw_in              = snk_ff;
         end
         OP_Q_READ: begin
            if (!sts.q_empty && !sts.sink_found) head_in = head_ff + CNT_BITS'(1);
         end
         OP_Q_TAKE: begin
            u_in = que_rd_ff;
            v_in = '0;
         end
         OP_W_PARW, OP_U_PARW: uw_in = par_rd_ff;
         OP_W_RES: begin
            if (res[FLOW_BITS-1:0] < aug_ff) aug_in = res[FLOW_BITS-1:0];
            vw_in = at_src ? snk_ff : uw_ff;
         end
         OP_U_REV: begin
            if (at_src) total_in = total_ff + aug_ff[TOTAL_BITS-1:0];
            else        vw_in = uw_ff;
         end
         default: ;
      endcase

      if (cmd.load_rsp) begin
         flow_sum_in = total_ff;
         status_in   = (stat_ff == ST_OK && err_ff) ? ST_RANGE : stat_ff;
         err_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_BITS'(MAX_NODES);
         src_ff        <= '0;
         snk_ff        <= NODE_BITS'(1);
         err_ff        <= 1'b0;
         total_ff      <= '0;
         pv_ff         <= 1'b0;
         clr_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         v_ff          <= '0;
         visited_ff    <= '0;
         stat_ff       <= ST_OK;
      end else begin
         node_count_ff <= node_count_in;
         src_ff        <= src_in;
         snk_ff        <= snk_in;
         err_ff        <= err_in;
         total_ff      <= total_in;
         pv_ff         <= pv_in;
         clr_ff        <= clr_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         v_ff          <= v_in;
         visited_ff    <= visited_in;
         stat_ff       <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      aug_ff      <= aug_in;
      u_ff        <= u_in;
      pidx_ff     <= pidx_in;
      vw_ff       <= vw_in;
      uw_ff       <= uw_in;
      flow_sum_ff <= flow_sum_in;
      status_ff   <= status_in;
   end

   assign flow_sum = flow_sum_ff;
   assign status   = status_ff;
endmodule
`default_nettype wire

/* sv/mfap_ctrl.sv */
// Controller: sequences load, clearing pass, BFS rounds, augment and result.
`default_nettype none
module mfap_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic              req_last,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfap_pkg::cmd_type cmd,
   input  mfap_pkg::sts_type sts
);
   import mfap_pkg::*;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_INIT   = 14'b00000000000100,
      S_Q_RD   = 14'b00000000001000,
      S_Q_WAIT = 14'b00000000010000,
      S_SCAN   = 14'b00000000100000,
      S_W_PAR  = 14'b00000001000000,
      S_W_PARW = 14'b00000010000000,
      S_W_RES  = 14'b00000100000000,
      S_U_PAR  = 14'b00001000000000,
      S_U_PARW = 14'b00010000000000,
      S_U_FWD  = 14'b00100000000000,
      S_U_REV  = 14'b01000000000000,
      S_RESULT = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.load     = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.load = req_accept;
            if (req_accept && req_last) state_in = sts.run_ok ? S_INIT : S_RESULT;
         end
         S_INIT: begin
            cmd.op   = OP_BFS_INIT;
            state_in = S_Q_RD;
         end
         S_Q_RD: begin
            cmd.op = OP_Q_READ;
            if (sts.sink_found)   state_in = S_W_PAR;
            else if (sts.q_empty) state_in = S_RESULT;
            else                  state_in = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            cmd.op   = OP_Q_TAKE;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (sts.scan_done) state_in = S_Q_RD;
         end
         S_W_PAR: begin
            cmd.op   = OP_W_PAR;
            state_in = S_W_PARW;
         end
         S_W_PARW: begin
            cmd.op   = OP_W_PARW;
            state_in = S_W_RES;
         end
         S_W_RES: begin
            cmd.op   = OP_W_RES;
            state_in = sts.at_src ? S_U_PAR : S_W_PAR;
         end
         S_U_PAR: begin
            cmd.op   = OP_U_PAR;
            state_in = S_U_PARW;
         end
         S_U_PARW: begin
            cmd.op   = OP_U_PARW;
            state_in = S_U_FWD;
         end
         S_U_FWD: begin
            cmd.op   = OP_U_FWD;
            state_in = S_U_REV;
         end
         S_U_REV: begin
            cmd.op   = OP_U_REV;
            state_in = sts.at_src ? S_INIT : S_U_PAR;
         end
         S_RESULT: begin
            cmd.op = OP_RESULT;
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_CLEAR;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

/* sv/max_flow_augmenting_path_unit.sv */
// Top level of the Edmonds-Karp max-flow unit.
// Edge beats load one per cycle while the unit is idle; each in-range beat writes one
// entry of a 32x32 capacity memory. The beat marked last starts a run: each BFS round
// scans the capacity and flow memories for every dequeued node (one capacity/flow
// memory read per cycle), then walks the path back from the sink for the minimum
// search and walks it again for the flow update. After each result and after reset
// a clearing pass zeros all 1024 entries of the capacity and flow memories (one entry
// a cycle); no edge beat is taken then, CSR writes are. The result register lets the
// unit load the next graph while a result beat waits.
`default_nettype none
module max_flow_augmenting_path_unit (
   input  logic                                clock,
   input  logic                                reset,
   mfap_req_if.sink                            req_bus,
   mfap_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [mfap_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfap_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mfap_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready, req_accept;

   assign req_accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   mfap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_last   (req_bus.last),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   mfap_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .from_node     (req_bus.from_node),
      .to_node       (req_bus.to_node),
      .edge_capacity (req_bus.edge_capacity),
      .last          (req_bus.last),
      .flow_sum      (rsp_bus.flow_sum),
      .status        (rsp_bus.status)
   );
endmodule
`default_nettype wire

/* sv/mfap_checker.sv */
// Port-level checker for the max-flow unit, bound to the top level.
`default_nettype none
`include "max_flow_augmenting_path_unit_assert.svh"
module mfap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [36:0] flow_sum,
   input logic [1:0]  status
);
   import mfap_pkg::*;

   logic        status_legal;
   logic        same_node_rsp;
   logic        flow_zero;
   logic        rsp_stall;
   logic [38:0] rsp_beat;

   assign status_legal  = (status == ST_OK) || (status == ST_SAME_NODE) || (status == ST_RANGE);
   assign same_node_rsp = rsp_valid && (status == ST_SAME_NODE);
   assign flow_zero     = (flow_sum == '0);
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_beat      = {flow_sum, status};

   `MFAP_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, status_legal, "illegal status code")
   `MFAP_ASSERT_NOW(a_same_node_zero, clock, reset, same_node_rsp, flow_zero, "flow with src == snk")
   `MFAP_ASSERT_ALWAYS_NEXT(a_clear_after_reset, clock, reset, !req_ready, "beat during clear")
   `MFAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat), "beat moved")
endmodule

bind max_flow_augmenting_path_unit mfap_checker u_mfap_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .flow_sum  (rsp_bus.flow_sum),
   .status    (rsp_bus.status)
);
`default_nettype wire

/* test/tb_max_flow_augmenting_path_unit.sv */
// Testbench for the max-flow unit: directed and random graphs checked against a flow predictor.
`default_nettype none
module tb_max_flow_augmenting_path_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mfap_pkg::*;

   localparam int PERIOD      = 20;
   localparam int DRAIN_WAIT  = 1200;    // clearing pass plus margin
   localparam int CYCLE_LIMIT = 20000000;
   localparam int RAND_ITEMS  = 1500;
   localparam int QUIET_AFTER = 1300;

   typedef struct {
      logic [36:0] flow;
      logic [1:0]  status;
   } flow_result_type;

   typedef struct {
      logic [5:0]  nodes;
      logic [4:0]  src;
      logic [4:0]  snk;
      logic [4:0]  from_n;
      logic [4:0]  to_n;
      logic [31:0] cap;
      bit          last;
      bit          known;
      logic [36:0] flow;
      logic [1:0]  status;
   } edge_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   mfap_req_if req_bus();
   mfap_rsp_if rsp_bus();

   max_flow_augmenting_path_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #(PERIOD/2) clock = ~clock;

   // predictor state
   longint unsigned cap_mem [MAX_NODES][MAX_NODES];
   longint          flow_mem[MAX_NODES][MAX_NODES];
   bit              range_hit;
   logic [5:0]      node_cnt_reg;
   logic [4:0]      src_reg, snk_reg;

   flow_result_type flow_expect_q[$];
   int  beats_sent, results_checked, graphs_run, fail_count, cycle_count;
   bit  quiet;

   function automatic int active_nodes();
      if (node_cnt_reg < 2) return 2;
      if (node_cnt_reg > MAX_NODES) return MAX_NODES;
      return int'(node_cnt_reg);
   endfunction

   // one BFS round; fills parents, returns 1 when the sink is reached
   function automatic bit find_path(input int n, input int s, input int t,
                                    output int par[MAX_NODES]);
      int q[MAX_NODES];
      int head, tail, u;
      head = 0;
      tail = 0;
      for (int i = 0; i < MAX_NODES; i++) par[i] = -1;
      par[s] = s;
      q[tail++] = s;
      while (head < tail && par[t] < 0) begin
         u = q[head++];
         for (int v = 0; v < n; v++) begin
            if (par[v] < 0 && longint'(cap_mem[u][v]) - flow_mem[u][v] > 0) begin
               par[v] = u;
               if (tail < MAX_NODES) q[tail++] = v;
            end
         end
      end
      return par[t] >= 0;
   endfunction

   function automatic longint unsigned graph_flow(input int n, input int s, input int t);
      int par[MAX_NODES];
      int u, v;
      longint aug, r;
      longint unsigned total;
      total = 0;
      foreach (flow_mem[i, j]) flow_mem[i][j] = 0;
      while (find_path(n, s, t, par)) begin
         aug = 64'd1000000000000000000;
         for (v = t; v != s; v = u) begin
            u = par[v];
            r = longint'(cap_mem[u][v]) - flow_mem[u][v];
            if (r < aug) aug = r;
         end
         for (v = t; v != s; v = u) begin
            u = par[v];
            flow_mem[u][v] += aug;
            flow_mem[v][u] -= aug;
         end
         total += longint'(aug);
      end
      return total;
   endfunction

   function automatic bit predict_edge(input logic [4:0] f, input logic [4:0] t,
                                       input logic [31:0] c, input bit l,
                                       output flow_result_type res);
      int n;
      n = active_nodes();
      if (f < n && t < n) cap_mem[f][t] = c;
      else range_hit = 1'b1;
      if (!l) return 1'b0;
      res.flow = '0;
      res.status = ST_OK;
      if (src_reg == snk_reg) res.status = ST_SAME_NODE;
      else if (src_reg >= n || snk_reg >= n) res.status = ST_RANGE;
      else begin
         res.flow = 37'(graph_flow(n, int'(src_reg), int'(snk_reg)));
         if (range_hit) res.status = ST_RANGE;
      end
      foreach (cap_mem[i, j]) cap_mem[i][j] = 0;
      range_hit = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_edge(input logic [4:0] f, input logic [4:0] t, input logic [31:0] c,
                            input bit l, input bit known, input flow_result_type typed);
      flow_result_type res;
      req_bus.valid <= 1'b1;
      req_bus.from_node <= f;
      req_bus.to_node <= t;
      req_bus.edge_capacity <= c;
      req_bus.last <= l;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      if (predict_edge(f, t, c, l, res)) begin
         graphs_run++;
         if (known) flow_expect_q.insert(flow_expect_q.size(), typed);
         else       flow_expect_q.insert(flow_expect_q.size(), res);
      end
   endtask

   // stop sending and let every result come out, then the clearing pass
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (flow_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_config(input logic [5:0] nodes, input logic [4:0] s, input logic [4:0] t);
      csr_we <= 1'b1;
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= nodes;
      @(posedge clock);
      csr_index <= CSR_SOURCE_NODE;
      csr_wdata <= {1'b0, s};
      @(posedge clock);
      csr_index <= CSR_SINK_NODE;
      csr_wdata <= {1'b0, t};
      @(posedge clock);
      csr_we <= 1'b0;
      node_cnt_reg = nodes;
      src_reg = s;
      snk_reg = t;
   endtask

   function automatic logic [31:0] pick_cap();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   // random graph, biased toward edges leaving the source and entering the sink
   task automatic send_graph();
      int n, cnt;
      logic [4:0] f, t;
      flow_result_type none;
      none.flow = '0;
      none.status = ST_OK;
      n = active_nodes();
      cnt = (n <= 8) ? $urandom_range(1, 12) : $urandom_range(10, 60);
      for (int k = 0; k < cnt; k++) begin
         if (!quiet && $urandom_range(0, 7) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         if ($urandom_range(0, 11) == 0) begin
            f = 5'($urandom_range(0, 31));
            t = 5'($urandom_range(0, 31));
         end else begin
            f = 5'($urandom_range(0, n - 1));
            t = 5'($urandom_range(0, n - 1));
            case ($urandom_range(0, 5))
               0: f = src_reg;
               1: t = snk_reg;
               default: ;
            endcase
         end
         send_edge(f, t, pick_cap(), k == cnt - 1, 1'b0, none);
      end
   endtask

   task automatic random_config();
      logic [5:0] nodes;
      int n;
      logic [4:0] s, t;
      case ($urandom_range(0, 19))
         0: nodes = 6'd0;
         1: nodes = 6'd63;
         2: nodes = 6'd32;
         3: nodes = 6'd2;
         default: nodes = 6'($urandom_range(3, 8));
      endcase
      n = (nodes < 2) ? 2 : (nodes > MAX_NODES) ? MAX_NODES : int'(nodes);
      case ($urandom_range(0, 9))
         0: begin
            s = 5'($urandom_range(0, n - 1));
            t = s;
         end
         1: begin
            s = 5'($urandom_range(0, 31));
            t = 5'($urandom_range(0, 31));
         end
         default: begin
            s = 5'($urandom_range(0, n - 1));
            do t = 5'($urandom_range(0, n - 1)); while (t == s);
         end
      endcase
      write_config(nodes, s, t);
   endtask

   edge_row_type directed[] = '{
      '{6'd32, 5'd0, 5'd1, 5'd0, 5'd1, 32'hFFFF_FFFF, 1, 1, 37'hFFFF_FFFF, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd1, 5'd0, 32'd5, 1, 1, 37'd0, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd0, 5'd0, 32'd7, 0, 0, 37'd0, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd0, 5'd1, 32'd3, 1, 1, 37'd3, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd0, 5'd2, 32'd10, 0, 0, 37'd0, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd2, 5'd1, 32'd4, 0, 0, 37'd0, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd0, 5'd1, 32'd1, 0, 0, 37'd0, ST_OK},
      '{6'd32, 5'd0, 5'd1, 5'd31, 5'd31, 32'd0, 1, 0, 37'd0, ST_OK},
      '{6'd32, 5'd3, 5'd3, 5'd0, 5'd1, 32'd9, 1, 1, 37'd0, ST_SAME_NODE},
      '{6'd4, 5'd0, 5'd3, 5'd5, 5'd1, 32'd9, 0, 0, 37'd0, ST_OK},
      '{6'd4, 5'd0, 5'd3, 5'd0, 5'd3, 32'd6, 1, 1, 37'd6, ST_RANGE},
      '{6'd4, 5'd0, 5'd5, 5'd0, 5'd1, 32'd2, 1, 1, 37'd0, ST_RANGE},
      '{6'd0, 5'd0, 5'd1, 5'd0, 5'd1, 32'd8, 1, 1, 37'd8, ST_OK},
      '{6'd63, 5'd31, 5'd0, 5'd31, 5'd0, 32'd1, 0, 0, 37'd0, ST_OK},
      '{6'd63, 5'd31, 5'd0, 5'd31, 5'd0, 32'd2, 1, 1, 37'd2, ST_OK},
      '{6'd4, 5'd2, 5'd2, 5'd7, 5'd7, 32'd1, 1, 1, 37'd0, ST_SAME_NODE},
      '{6'd8, 5'd0, 5'd7, 5'd0, 5'd1, 32'd5, 0, 0, 37'd0, ST_OK},
      '{6'd8, 5'd0, 5'd7, 5'd1, 5'd7, 32'd3, 0, 0, 37'd0, ST_OK},
      '{6'd8, 5'd0, 5'd7, 5'd0, 5'd7, 32'd4, 1, 0, 37'd0, ST_OK}
   };

   // result checker
   always @(posedge clock) begin
      flow_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (flow_expect_q.size() == 0) begin
            $error("result beat with nothing expected: flow_sum %0d status %0d",
                   rsp_bus.flow_sum, rsp_bus.status);
            fail_count++;
         end else begin
            exp_res = flow_expect_q.pop_front();
            results_checked++;
            if (rsp_bus.flow_sum !== exp_res.flow) begin
               $error("flow_sum expected %0d actual %0d", exp_res.flow, rsp_bus.flow_sum);
               fail_count++;
            end
            if (rsp_bus.status !== exp_res.status) begin
               $error("status expected %0d actual %0d", exp_res.status, rsp_bus.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  flow_expect_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (!quiet) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   initial begin
      flow_result_type typed;
      cycle_count = 0;
      fail_count = 0;
      beats_sent = 0;
      results_checked = 0;
      graphs_run = 0;
      quiet = 1'b0;
      range_hit = 1'b0;
      node_cnt_reg = 6'd32;
      src_reg = 5'd0;
      snk_reg = 5'd1;
      foreach (cap_mem[i, j]) cap_mem[i][j] = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.from_node <= '0;
      req_bus.to_node <= '0;
      req_bus.edge_capacity <= '0;
      req_bus.last <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].nodes != node_cnt_reg || directed[i].src != src_reg ||
             directed[i].snk != snk_reg) begin
            drain();
            write_config(directed[i].nodes, directed[i].src, directed[i].snk);
         end
         typed.flow = directed[i].flow;
         typed.status = directed[i].status;
         send_edge(directed[i].from_n, directed[i].to_n, directed[i].cap,
                   directed[i].last, directed[i].known, typed);
      end

      while (beats_sent < RAND_ITEMS) begin
         drain();
         random_config();
         for (int g = 0; g < 6 && beats_sent < RAND_ITEMS; g++) begin
            quiet = beats_sent >= QUIET_AFTER;
            send_graph();
         end
      end
      req_bus.valid <= 1'b0;

      while (flow_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d edge beats in %0d graphs, %0d flow results compared",
               beats_sent, graphs_run, results_checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/mfap_pkg.sv
sv/mfap_if.sv
sv/mfap_datapath.sv
sv/mfap_ctrl.sv
sv/max_flow_augmenting_path_unit.sv
sv/mfap_checker.sv
test/tb_max_flow_augmenting_path_unit.sv
